@@ src/accel_event_filter_core_assert.svh @@
// Assertion macros shared by the accel event filter RTL.
// No dependencies.
`ifndef ACCEL_EVENT_FILTER_CORE_ASSERT_SVH
`define ACCEL_EVENT_FILTER_CORE_ASSERT_SVH
// implication checked at every edge out of reset
`define AEF_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define AEF_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

@@ src/aef_pkg.sv @@
// Shared types and constants for the accel event filter.
// No dependencies.
package aef_pkg;
	localparam int HISTORY_MAX   = 64;
	localparam int SAMPLE_BITS   = 16;
	localparam int FRACTION_BITS = 8;
	localparam int OUT_BITS      = SAMPLE_BITS + FRACTION_BITS + 2;
	localparam int PTR_BITS      = $clog2(HISTORY_MAX);
	localparam int LEN_BITS      = 7;
	localparam int SUM_BITS      = 32;
	localparam int RING_DEPTH    = 4 * HISTORY_MAX;
	localparam int RING_ABITS    = $clog2(RING_DEPTH);

	localparam logic [1:0] EV_AXIS  = 2'd0;
	localparam logic [1:0] EV_SYNC  = 2'd1;
	localparam logic [1:0] EV_CAPT  = 2'd2;
	localparam logic [1:0] EV_OTHER = 2'd3;
	localparam logic [1:0] AX_X    = 2'd0;
	localparam logic [1:0] AX_Y    = 2'd1;
	localparam logic [1:0] AX_Z    = 2'd2;
	localparam logic [1:0] AX_NONE = 2'd3;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_GAIN   = 2'd1;
	localparam logic [1:0] REG_LEN    = 2'd2;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam logic [2:0] M_MEAN   = 3'd0;
	localparam logic [2:0] M_SMOOTH = 3'd1;
	localparam logic [2:0] M_LIN3   = 3'd2;
	localparam logic [2:0] M_LIN2   = 3'd3;
	localparam logic [2:0] M_L3S    = 3'd4;
	localparam logic [2:0] M_SL3    = 3'd5;
	localparam logic [2:0] M_L2S    = 3'd6;
	localparam logic [2:0] M_SL2    = 3'd7;

	typedef logic signed [OUT_BITS-1:0] val_t;

	function automatic val_t sat_out(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (OUT_BITS - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) return hi[OUT_BITS-1:0];
		if (v < lo) return lo[OUT_BITS-1:0];
		return v[OUT_BITS-1:0];
	endfunction
endpackage

@@ src/accel_event_filter_core.sv @@
// Top level of the accel event filter: stream in, stream out, config port.
// Depends on aef_pkg and accel_event_filter_core_assert.svh.

// One event is taken at a time; axis and capture events are done in the idle
// state. A sync event runs a sequencer over the three axes, one axis after
// another; in mean mode each axis reads the mean ring (a one-port-read
// synchronous memory) and divides the running sum by the history length with
// a restoring divider, one quotient bit per cycle; in the other modes each
// axis runs one or two filter stages instead. The last axis waits while
// the previous result has not been taken; axis and capture events are still
// taken while a result waits.
// After reset, and after each write of history_length, a clearing pass
// zeroes the first 192 ring entries; no event is taken during it.
module accel_event_filter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sample_value
	input  logic [3:0]  s_tuser,   // event_kind, axis_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // out_y, out_x, out_z, zero fill
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import aef_pkg::*;
	`include "accel_event_filter_core_assert.svh"

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b00000001,
		ST_IDLE  = 8'b00000010,
		ST_READ  = 8'b00000100,
		ST_MEM   = 8'b00001000,
		ST_DIV   = 8'b00010000,
		ST_F1    = 8'b00100000,
		ST_F2    = 8'b01000000,
		ST_OUT   = 8'b10000000
	} state_t;

	state_t state_q;
	logic [2:0]  mode_q;
	logic [15:0] gain_q;
	logic [LEN_BITS-1:0] hlen_q;
	logic signed [SAMPLE_BITS-1:0] raw_q [3];
	val_t zoff_q [3];
	val_t last_q [3];
	val_t smooth_q [3];
	val_t rhist_q [3][3];
	logic signed [SUM_BITS-1:0] sum_q [3];
	logic [PTR_BITS-1:0] mptr_q;
	logic [1:0] rptr_q;
	logic [1:0] axis_q;
	logic [RING_ABITS-1:0] clr_q;
	val_t v_q;
	val_t res_q [3];

	val_t ring_mem [RING_DEPTH];
	val_t ring_rd_q;
	logic ring_we;
	logic [RING_ABITS-1:0] ring_addr;
	val_t ring_wd;

	// divider
	logic [5:0] dcnt_q;
	logic [SUM_BITS-1:0] dnum_q;
	logic [SUM_BITS:0] drem_q;
	logic dneg_q;

	logic [LEN_BITS-1:0] len_eff;
	logic [PTR_BITS-1:0] p_eff;
	logic [1:0] rp3, rp2, q31, q32, q2;
	logic accept;
	logic last_axis;

	always_comb begin
		if (hlen_q == '0) len_eff = LEN_BITS'(1);
		else if (hlen_q > LEN_BITS'(HISTORY_MAX)) len_eff = LEN_BITS'(HISTORY_MAX);
		else len_eff = hlen_q;
		p_eff = ({1'b0, mptr_q} >= len_eff) ? '0 : mptr_q;
		case (rptr_q)
			2'd0: begin rp3 = 2'd1; q31 = 2'd2; q32 = 2'd0; end
			2'd1: begin rp3 = 2'd2; q31 = 2'd0; q32 = 2'd1; end
			default: begin rp3 = 2'd0; q31 = 2'd1; q32 = 2'd2; end
		endcase
		// lin2 slot is (ptr mod 3 + 1) mod 2
		rp2 = (rptr_q == 2'd1) ? 2'd0 : 2'd1;
		q2 = {1'b0, ~rp2[0]};
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign last_axis = (axis_q == 2'd2);

	// memory port
	always_comb begin
		ring_we = 1'b0;
		ring_addr = {axis_q, p_eff};
		ring_wd = v_q;
		if (state_q == ST_CLEAR) begin
			ring_we = 1'b1;
			ring_addr = clr_q;
			ring_wd = '0;
		end else if (state_q == ST_MEM) begin
			ring_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) ring_mem[ring_addr] <= ring_wd;
		ring_rd_q <= ring_mem[ring_addr];
	end

	function automatic logic signed [63:0] fshift(input logic signed [63:0] v, input int s);
		return v >>> s;
	endfunction

	logic signed [63:0] diff, msum, sm_acc, l3_acc, l2_acc;
	logic signed [SUM_BITS-1:0] sum_new;
	val_t sm_out, l_out, quot;
	logic [2:0] stage_mode;
	logic do_lin2;

	always_comb begin
		diff = 64'(raw_q[axis_q]) * (64'sd1 <<< FRACTION_BITS) - 64'(zoff_q[axis_q]);
		msum = 64'(sum_q[axis_q]) + 64'(v_q) - 64'(ring_rd_q);
		sum_new = msum[SUM_BITS-1:0];
		sm_acc = 64'(smooth_q[axis_q]) * $signed({48'd0, gain_q})
			+ 64'(v_q) * $signed(64'(17'h10000 - {1'b0, gain_q})) + 64'sd32768;
		sm_out = sat_out(fshift(sm_acc, 16));
		l3_acc = 64'(v_q) + 64'sd3 * 64'(rhist_q[q31][axis_q])
			+ 64'sd3 * 64'(rhist_q[q32][axis_q]) + 64'(rhist_q[rp3][axis_q]) + 64'sd4;
		l2_acc = 64'(v_q) + 64'sd2 * 64'(rhist_q[q2][axis_q])
			+ 64'(rhist_q[rp2][axis_q]) + 64'sd2;
		do_lin2 = (mode_q == M_LIN2 || mode_q == M_L2S || mode_q == M_SL2);
		l_out = do_lin2 ? sat_out(fshift(l2_acc, 2)) : sat_out(fshift(l3_acc, 3));
		quot = dneg_q ? sat_out(-64'(dnum_q)) : sat_out(64'(dnum_q));
		stage_mode = mode_q;
	end

	// first filter stage is lin for modes 2,3,4,6 and smooth for 1,5,7
	logic first_lin, has_second;
	always_comb begin
		first_lin = (mode_q == M_LIN3 || mode_q == M_LIN2 || mode_q == M_L3S
			|| mode_q == M_L2S);
		has_second = (stage_mode == M_L3S || stage_mode == M_SL3
			|| stage_mode == M_L2S || stage_mode == M_SL2);
	end

	logic [SUM_BITS:0] dtrial;
	assign dtrial = {drem_q[SUM_BITS-1:0], dnum_q[SUM_BITS-1]} - (SUM_BITS+1)'(len_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			mode_q <= M_SMOOTH;
			gain_q <= 16'd58982;
			hlen_q <= LEN_BITS'(8);
			clr_q <= '0;
			mptr_q <= '0;
			rptr_q <= '0;
			axis_q <= '0;
			m_tvalid <= 1'b0;
			dcnt_q <= '0;
			for (int a = 0; a < 3; a++) begin
				raw_q[a] <= '0;
				zoff_q[a] <= '0;
				last_q[a] <= '0;
				smooth_q[a] <= '0;
				sum_q[a] <= '0;
				for (int b = 0; b < 3; b++) rhist_q[b][a] <= '0;
			end
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: mode_q <= cfg_data[2:0];
					REG_GAIN: gain_q <= cfg_data;
					REG_LEN: begin
						hlen_q <= cfg_data[LEN_BITS-1:0];
						for (int a = 0; a < 3; a++) sum_q[a] <= '0;
						mptr_q <= '0;
						clr_q <= '0;
						state_q <= ST_CLEAR;
					end
					default: ;
				endcase
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == RING_ABITS'(3 * HISTORY_MAX - 1) && !cfg_we)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser[1:0])
							EV_AXIS: begin
								case (s_tuser[3:2])
									AX_X: raw_q[1] <= s_tdata;
									AX_Y: raw_q[0] <= s_tdata;
									AX_Z: raw_q[2] <= s_tdata;
									default: ;
								endcase
							end
							EV_CAPT: for (int a = 0; a < 3; a++) zoff_q[a] <= last_q[a];
							EV_SYNC: begin
								axis_q <= '0;
								state_q <= ST_READ;
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					v_q <= sat_out(diff);
					state_q <= (mode_q == M_MEAN) ? ST_MEM : ST_F1;
				end
				ST_MEM: begin
					// ring_rd_q holds the old entry here
					sum_q[axis_q] <= sum_new;
					dneg_q <= sum_new[SUM_BITS-1];
					dnum_q <= sum_new[SUM_BITS-1] ? -sum_new : sum_new;
					drem_q <= '0;
					dcnt_q <= 6'(SUM_BITS);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (dcnt_q == '0) begin
						v_q <= quot;
						state_q <= ST_OUT;
					end else begin
						dcnt_q <= dcnt_q - 1'b1;
						if (!dtrial[SUM_BITS]) begin
							drem_q <= dtrial;
							dnum_q <= {dnum_q[SUM_BITS-2:0], 1'b1};
						end else begin
							drem_q <= {drem_q[SUM_BITS-1:0], dnum_q[SUM_BITS-1]};
							dnum_q <= {dnum_q[SUM_BITS-2:0], 1'b0};
						end
					end
				end
				ST_F1: begin
					if (first_lin) begin
						v_q <= l_out;
						rhist_q[do_lin2 ? rp2 : rp3][axis_q] <= l_out;
					end else begin
						v_q <= sm_out;
						smooth_q[axis_q] <= sm_out;
					end
					state_q <= has_second ? ST_F2 : ST_OUT;
				end
				ST_F2: begin
					if (!first_lin) begin
						v_q <= l_out;
						rhist_q[do_lin2 ? rp2 : rp3][axis_q] <= l_out;
					end else begin
						v_q <= sm_out;
						smooth_q[axis_q] <= sm_out;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					last_q[axis_q] <= v_q;
					if (last_axis) begin
						// hold here while the previous result is still waiting
						if (!m_tvalid || m_tready) begin
							res_q[0] <= last_q[0];
							res_q[1] <= last_q[1];
							res_q[2] <= v_q;
							m_tvalid <= 1'b1;
							state_q <= ST_IDLE;
							if (mode_q == M_MEAN)
								mptr_q <= ({1'b0, p_eff} + 1'b1 >= len_eff) ? '0 : p_eff + 1'b1;
							if (mode_q != M_MEAN && mode_q != M_SMOOTH)
								rptr_q <= do_lin2 ? rp2 : rp3;
						end
					end else begin
						axis_q <= axis_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tdata = {2'b00, res_q[2], res_q[1], res_q[0]};

	`AEF_ASSERT_IMP(a_no_take_in_clear, clk, arst_n, state_q == ST_CLEAR, !s_tready)
	`AEF_ASSERT_IMP(a_axis_range, clk, arst_n, state_q != ST_IDLE, axis_q != 2'd3)
	`AEF_ASSERT_NEXT(a_valid_on_finish, clk, arst_n, state_q == ST_OUT && last_axis, m_tvalid)
endmodule
